@@ design/bmp24_pixel_stream_unpacker_assert.svh @@
// ----------------------------------------------------------------------------
// bmp24 unpacker assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef BMP24_PIXEL_STREAM_UNPACKER_ASSERT_SVH
`define BMP24_PIXEL_STREAM_UNPACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BMP24U_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmp24 unpacker: same-cycle check failed");

// next-cycle implication
`define BMP24U_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmp24 unpacker: next-cycle check failed");

`else

`define BMP24U_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BMP24U_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ design/bmp24u_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp24u_pkg
// Shared constants, result codes and item types of the 24-bit bitmap unpacker.
// ----------------------------------------------------------------------------
package bmp24u_pkg;

   // header layout
   localparam int HDR_LEN    = 54;
   localparam int WIDTH_OFS  = 18;
   localparam int HEIGHT_OFS = 22;
   localparam int DEPTH_OFS  = 28;
   localparam int WORD_BYTES = 4;
   localparam int BPP_24     = 24;
   localparam int POS_W      = 6;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int KIND_W    = 2;
   localparam int DIM_OUT_W = 13;
   localparam int INDEX_W   = 24;

   // result codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // one input transfer
   typedef struct packed {
      logic              file_start;
      logic [BYTE_W-1:0] data_byte;
   } in_item_type;

   // one result transfer
   typedef struct packed {
      kind_type             kind;
      logic [BYTE_W-1:0]    red;
      logic [BYTE_W-1:0]    green;
      logic [BYTE_W-1:0]    blue;
      logic [INDEX_W-1:0]   pixel_index;
      logic [DIM_OUT_W-1:0] image_width;
      logic [DIM_OUT_W-1:0] image_height;
      logic                 last_pixel;
   } result_type;

   // input register to parser
   typedef struct packed {
      logic        valid;
      in_item_type item;
   } in_stage_type;

endpackage

@@ design/bmp24u_if.sv @@
// ----------------------------------------------------------------------------
// bmp24u channel interfaces
// Valid/ready channels for the raw byte stream and for the result stream.
// ----------------------------------------------------------------------------

// raw file bytes
interface bmp24u_req_if;
   logic                         valid;
   logic                         ready;
   logic                         file_start;
   logic [bmp24u_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output file_start, output data_byte, input ready);
   modport sink   (input valid, input file_start, input data_byte, output ready);
endinterface

// pixels, header status and errors
interface bmp24u_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bmp24u_pkg::KIND_W-1:0]    kind;
   logic [bmp24u_pkg::BYTE_W-1:0]    red;
   logic [bmp24u_pkg::BYTE_W-1:0]    green;
   logic [bmp24u_pkg::BYTE_W-1:0]    blue;
   logic [bmp24u_pkg::INDEX_W-1:0]   pixel_index;
   logic [bmp24u_pkg::DIM_OUT_W-1:0] image_width;
   logic [bmp24u_pkg::DIM_OUT_W-1:0] image_height;
   logic                            last_pixel;

   modport source (output valid, output kind, output red, output green, output blue,
                   output pixel_index, output image_width, output image_height,
                   output last_pixel, input ready);
   modport sink   (input valid, input kind, input red, input green, input blue,
                   input pixel_index, input image_width, input image_height,
                   input last_pixel, output ready);
endinterface

@@ design/bmp24u_in_reg.sv @@
// ----------------------------------------------------------------------------
// bmp24u_in_reg
// Input register: captures one byte transfer and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module bmp24u_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   bmp24u_req_if.sink               req_ch,
   input  logic                     take,
   output bmp24u_pkg::in_stage_type stage
);

   logic                    valid_ff;
   logic                    valid_in;
   bmp24u_pkg::in_item_type item_ff;
   logic                    req_fire;

   // free when empty or drained this cycle
   assign req_ch.ready = !valid_ff || take;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign valid_in     = req_fire || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.file_start <= req_ch.file_start;
         item_ff.data_byte  <= req_ch.data_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

@@ design/bmp24u_parser.sv @@
// ----------------------------------------------------------------------------
// bmp24u_parser
// Header capture and check, BGR triple assembly, row padding skip and
// destination index tracking; one byte per cycle while take is high.
// ----------------------------------------------------------------------------
module bmp24u_parser #(
   parameter int MAX_DIM = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  bmp24u_pkg::in_item_type item,
   output logic                    res_valid,
   output bmp24u_pkg::result_type  res
);

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int POS_W   = bmp24u_pkg::POS_W;
   localparam int BYTE_W  = bmp24u_pkg::BYTE_W;
   localparam int WORD_W  = bmp24u_pkg::WORD_W;
   localparam int INDEX_W = bmp24u_pkg::INDEX_W;
   localparam int OUT_W   = bmp24u_pkg::DIM_OUT_W;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      CH_BLUE,
      CH_GREEN,
      CH_RED
   } chan_type;

   // control state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   chan_type           chan_ff, chan_in;
   logic [1:0]         pad_ff, pad_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic [DIM_W-1:0]   rows_ff, rows_in;
   logic [INDEX_W-1:0] next_ff, next_in;

   // captured payload
   logic [WORD_W-1:0]  width_word_ff, width_word_in;
   logic [WORD_W-1:0]  height_word_ff, height_word_in;
   logic [WORD_W-1:0]  depth_word_ff, depth_word_in;
   logic [BYTE_W-1:0]  blue_ff, blue_in;
   logic [BYTE_W-1:0]  green_ff, green_in;
   logic [1:0]         row_pad_ff, row_pad_in;
   logic [INDEX_W-1:0] prod_ff, prod_in;

   // working signals
   phase_type          cur_phase;
   logic [POS_W-1:0]   cur_pos;
   logic [POS_W-1:0]   off_w, off_h, off_d;
   logic               in_w, in_h, in_d;
   logic               hdr_bad;
   logic [INDEX_W-1:0] height_m1;
   logic [2*INDEX_W-1:0] prod_full;
   logic [DIM_W-1:0]   wdim;
   logic [DIM_W-1:0]   col_inc;
   logic               row_end;
   logic               last_row;
   logic [INDEX_W-1:0] idx_inc;

   // a start flag restarts header parsing at this byte
   assign cur_phase = item.file_start ? PH_HEADER : phase_ff;
   assign cur_pos   = item.file_start ? '0 : pos_ff;

   // byte lanes of the three header words
   assign off_w = cur_pos - POS_W'(bmp24u_pkg::WIDTH_OFS);
   assign off_h = cur_pos - POS_W'(bmp24u_pkg::HEIGHT_OFS);
   assign off_d = cur_pos - POS_W'(bmp24u_pkg::DEPTH_OFS);
   assign in_w  = off_w < POS_W'(bmp24u_pkg::WORD_BYTES);
   assign in_h  = off_h < POS_W'(bmp24u_pkg::WORD_BYTES);
   assign in_d  = off_d < POS_W'(bmp24u_pkg::WORD_BYTES);

   // header check on settled words
   assign hdr_bad = (depth_word_ff != WORD_W'(bmp24u_pkg::BPP_24)) ||
                    (width_word_ff > WORD_W'(MAX_DIM)) ||
                    (height_word_ff > WORD_W'(MAX_DIM));

   // start index of the bottom row, registered ahead of header end
   assign height_m1 = height_word_ff[INDEX_W-1:0] - INDEX_W'(1);
   assign prod_full = height_m1 * width_word_ff[INDEX_W-1:0];
   assign prod_in   = prod_full[INDEX_W-1:0];

   // row position of the current pixel
   assign wdim     = width_word_ff[DIM_W-1:0];
   assign col_inc  = col_ff + DIM_W'(1);
   assign row_end  = col_inc == wdim;
   assign last_row = rows_ff == DIM_W'(1);
   assign idx_inc  = next_ff + INDEX_W'(1);

   // next state and result
   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      chan_in        = chan_ff;
      pad_in         = pad_ff;
      col_in         = col_ff;
      rows_in        = rows_ff;
      next_in        = next_ff;
      width_word_in  = width_word_ff;
      height_word_in = height_word_ff;
      depth_word_in  = depth_word_ff;
      blue_in        = blue_ff;
      green_in       = green_ff;
      row_pad_in     = row_pad_ff;
      res_valid      = 1'b0;
      res            = '0;
      if (take) begin
         case (cur_phase)
            PH_HEADER: begin
               phase_in = PH_HEADER;
               pos_in   = cur_pos + POS_W'(1);
               if (in_w) begin
                  width_word_in[{off_w[1:0], 3'b000} +: BYTE_W] = item.data_byte;
               end
               if (in_h) begin
                  height_word_in[{off_h[1:0], 3'b000} +: BYTE_W] = item.data_byte;
               end
               if (in_d) begin
                  depth_word_in[{off_d[1:0], 3'b000} +: BYTE_W] = item.data_byte;
               end
               if (cur_pos == POS_W'(bmp24u_pkg::HDR_LEN - 1)) begin
                  res_valid = 1'b1;
                  if (hdr_bad) begin
                     phase_in = PH_ERROR;
                     res.kind = bmp24u_pkg::KIND_ERROR;
                  end else begin
                     res.kind         = bmp24u_pkg::KIND_HEADER;
                     res.image_width  = width_word_ff[OUT_W-1:0];
                     res.image_height = height_word_ff[OUT_W-1:0];
                     col_in           = '0;
                     rows_in          = height_word_ff[DIM_W-1:0];
                     chan_in          = CH_BLUE;
                     pad_in           = '0;
                     // rows of 3*width bytes pad to 4: pad equals width mod 4
                     row_pad_in       = width_word_ff[1:0];
                     if ((width_word_ff == '0) || (height_word_ff == '0)) begin
                        phase_in = PH_DONE;
                        next_in  = '0;
                     end else begin
                        phase_in = PH_PIXELS;
                        next_in  = prod_ff;
                     end
                  end
               end
            end
            PH_PIXELS: begin
               if (pad_ff != 2'd0) begin
                  pad_in = pad_ff - 2'd1;
               end else begin
                  case (chan_ff)
                     CH_BLUE: begin
                        blue_in = item.data_byte;
                        chan_in = CH_GREEN;
                     end
                     CH_GREEN: begin
                        green_in = item.data_byte;
                        chan_in  = CH_RED;
                     end
                     CH_RED: begin
                        chan_in         = CH_BLUE;
                        res_valid       = 1'b1;
                        res.kind        = bmp24u_pkg::KIND_PIXEL;
                        res.red         = item.data_byte;
                        res.green       = green_ff;
                        res.blue        = blue_ff;
                        res.pixel_index = next_ff;
                        res.last_pixel  = last_row && row_end;
                        if (row_end) begin
                           col_in  = '0;
                           rows_in = rows_ff - DIM_W'(1);
                           // step back to the start of the row above
                           next_in = idx_inc - {width_word_ff[INDEX_W-2:0], 1'b0};
                           if (last_row) begin
                              phase_in = PH_DONE;
                           end else begin
                              pad_in = row_pad_ff;
                           end
                        end else begin
                           col_in  = col_inc;
                           next_in = idx_inc;
                        end
                     end
                     default: begin
                        chan_in = CH_BLUE;
                     end
                  endcase
               end
            end
            default: begin
               // done or error: bytes ignored until a new file starts
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         chan_ff  <= CH_BLUE;
         pad_ff   <= '0;
         col_ff   <= '0;
         rows_ff  <= '0;
         next_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
         pad_ff   <= pad_in;
         col_ff   <= col_in;
         rows_ff  <= rows_in;
         next_ff  <= next_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      width_word_ff  <= width_word_in;
      height_word_ff <= height_word_in;
      depth_word_ff  <= depth_word_in;
      blue_ff        <= blue_in;
      green_ff       <= green_in;
      row_pad_ff     <= row_pad_in;
      prod_ff        <= prod_in;
   end

endmodule

@@ design/bmp24u_out_reg.sv @@
// ----------------------------------------------------------------------------
// bmp24u_out_reg
// Result register: holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module bmp24u_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bmp24u_pkg::result_type res,
   output logic                   out_free,
   bmp24u_rsp_if.source           rsp_ch
);

   logic                   valid_ff;
   logic                   valid_in;
   bmp24u_pkg::result_type res_ff;

   // free when empty or being taken this cycle
   assign out_free = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = res_ff.kind;
   assign rsp_ch.red          = res_ff.red;
   assign rsp_ch.green        = res_ff.green;
   assign rsp_ch.blue         = res_ff.blue;
   assign rsp_ch.pixel_index  = res_ff.pixel_index;
   assign rsp_ch.image_width  = res_ff.image_width;
   assign rsp_ch.image_height = res_ff.image_height;
   assign rsp_ch.last_pixel   = res_ff.last_pixel;

endmodule

@@ design/bmp24_pixel_stream_unpacker.sv @@
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_unpacker
// Unpacks a 24-bit bitmap file, one byte per req_ch transfer, into rsp_ch
// results: one header-accepted or format-error result after byte 53, then
// one RGB pixel with its top-down index per BGR triple, bottom row first.
// Set file_start on the first byte of each file; row padding and bytes past
// the image cause no result. An accepted byte is held in the input register;
// its result is parsed into the result register and transfers on rsp_ch.
// One byte is accepted every cycle, set by the single parse stage, while
// the receiver keeps up. A stalled receiver holds the result register; the
// input register then takes a byte only while empty, and ready stays low
// until the result is taken.
// Reset empties both registers and parses from header byte 0.
// ----------------------------------------------------------------------------
`include "bmp24_pixel_stream_unpacker_assert.svh"

module bmp24_pixel_stream_unpacker #(
   parameter int MAX_DIM = 4096
) (
   input logic          clock,
   input logic          reset,
   bmp24u_req_if.sink   req_ch,
   bmp24u_rsp_if.source rsp_ch
);

   bmp24u_pkg::in_stage_type stage;
   bmp24u_pkg::result_type   res;
   logic                     res_valid;
   logic                     out_free;
   logic                     take;
   logic                     pixel_out;
   logic                     status_out;
   logic                     dims_clear;
   logic                     index_clear;

   // parser takes a byte when the result register can accept
   assign take = stage.valid && out_free;

   bmp24u_in_reg u_in_reg (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (take),
      .stage  (stage)
   );

   bmp24u_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .item      (stage.item),
      .res_valid (res_valid),
      .res       (res)
   );

   bmp24u_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take && res_valid),
      .res      (res),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   // result kind and field terms for the checks
   assign pixel_out   = rsp_ch.valid && (rsp_ch.kind == bmp24u_pkg::KIND_PIXEL);
   assign status_out  = rsp_ch.valid && (rsp_ch.kind != bmp24u_pkg::KIND_PIXEL);
   assign dims_clear  = (rsp_ch.image_width == '0) && (rsp_ch.image_height == '0);
   assign index_clear = (rsp_ch.pixel_index == '0) && (rsp_ch.last_pixel == 1'b0);

   // checks
   `BMP24U_ASSERT_IMPL(a_pixel_no_dims, clock, reset, pixel_out, dims_clear)
   `BMP24U_ASSERT_IMPL(a_status_no_pixel, clock, reset, status_out, index_clear)
   `BMP24U_ASSERT_NEXT(a_byte_kept, clock, reset, stage.valid && !take, stage.valid)

endmodule
